### design/aes128_inverse_key_schedule_core_assert.svh
// Assertion macros shared by the key schedule RTL.
// Depends on nothing; included by the top level only.
`ifndef AES128_INVERSE_KEY_SCHEDULE_CORE_ASSERT_SVH
`define AES128_INVERSE_KEY_SCHEDULE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AESIKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AESIKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/aesiks_pkg.sv
// Package for the AES-128 inverse key schedule: widths, S-box, round
// constants and the one-round backward step. No dependencies.
package aesiks_pkg;

    localparam int HALF_W     = 64;
    localparam int KEY_W      = 2 * HALF_W;
    localparam int NUM_ROUNDS = 10;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // One round backwards: round key i -> round key i-1.
    // rc is the round constant that produced key i.
    function automatic logic [KEY_W-1:0] inv_round(input logic [KEY_W-1:0] k,
                                                    input logic [7:0]       rc);
        logic [31:0] k0, k1, k2, k3;
        logic [31:0] p0, p1, p2, p3;
        logic [31:0] rot;
        logic [31:0] sub;
        k0  = k[127:96];
        k1  = k[95:64];
        k2  = k[63:32];
        k3  = k[31:0];
        p3  = k3 ^ k2;
        p2  = k2 ^ k1;
        p1  = k1 ^ k0;
        rot = {p3[23:0], p3[31:24]};
        sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
        p0  = k0 ^ sub ^ {rc, 24'h000000};
        return {p0, p1, p2, p3};
    endfunction

endpackage

### design/aesiks_key_in_if.sv
// Input channel carrying the last round key as two 64-bit halves.
// Depends on aesiks_pkg.
interface aesiks_key_in_if;
    logic                          valid;
    logic                          ready;
    logic [aesiks_pkg::HALF_W-1:0] last_key_hi;
    logic [aesiks_pkg::HALF_W-1:0] last_key_lo;

    modport source (output valid, output last_key_hi, output last_key_lo, input ready);
    modport sink   (input valid, input last_key_hi, input last_key_lo, output ready);
endinterface

### design/aesiks_key_out_if.sv
// Output channel carrying the recovered cipher key as two 64-bit halves.
// Depends on aesiks_pkg.
interface aesiks_key_out_if;
    logic                          valid;
    logic                          ready;
    logic [aesiks_pkg::HALF_W-1:0] cipher_key_hi;
    logic [aesiks_pkg::HALF_W-1:0] cipher_key_lo;

    modport source (output valid, output cipher_key_hi, output cipher_key_lo, input ready);
    modport sink   (input valid, input cipher_key_hi, input cipher_key_lo, output ready);
endinterface

### design/aes128_inverse_key_schedule_core.sv
// AES-128 inverse key schedule, fully pipelined, one round per stage.
// Depends on aesiks_pkg, aesiks_key_in_if, aesiks_key_out_if and the assert header.
//
// Usage:
//   key_in  : valid/ready word channel, one round-10 key per word
//             (last_key_hi = bytes 0..7, last_key_lo = bytes 8..15, byte 0 in MSBs).
//   key_out : valid/ready word channel, one cipher key per word, same byte order.
//   Stages  : 10 register stages, one per backward round (S-box lookup on one
//             word plus XORs in each).
//   Rate    : one word per cycle while key_out is not stalled; the ten round
//             stages run concurrently.
//   Reset   : rst_n low clears every stage valid bit; data registers are left as is.
//   Stall   : when key_out holds a word that is not taken, the whole pipe freezes
//             and key_in.ready drops in the same cycle; nothing is lost or repeated.
//             A stall with an empty output stage does not hold up the pipe.
//   Words leave in the order they were accepted.
`include "aes128_inverse_key_schedule_core_assert.svh"

module aes128_inverse_key_schedule_core (
    input  logic               clk,
    input  logic               rst_n,
    aesiks_key_in_if.sink      key_in,
    aesiks_key_out_if.source   key_out
);

    localparam int N = aesiks_pkg::NUM_ROUNDS;
    localparam int W = aesiks_pkg::KEY_W;

    // stage s holds round key 9-s after backward round s
    logic [N-1:0] stage_vld_reg;
    logic [N-1:0] stage_vld_next;
    logic [W-1:0] stage_key_reg  [N];
    logic [W-1:0] stage_key_next [N];

    logic advance;
    logic in_fire;
    logic out_fire;

    // pipe moves unless the output stage holds an untaken word
    assign advance  = !stage_vld_reg[N-1] || key_out.ready;
    assign in_fire  = key_in.valid && key_in.ready;
    assign out_fire = key_out.valid && key_out.ready;

    assign key_in.ready = advance;

    assign stage_vld_next = {stage_vld_reg[N-2:0], key_in.valid};

    genvar s;
    generate
        for (s = 0; s < N; s++) begin : g_round
            if (s == 0) begin : g_first
                assign stage_key_next[s] = aesiks_pkg::inv_round(
                    {key_in.last_key_hi, key_in.last_key_lo},
                    aesiks_pkg::RCON[N-1-s]);
            end
            else begin : g_rest
                assign stage_key_next[s] = aesiks_pkg::inv_round(
                    stage_key_reg[s-1],
                    aesiks_pkg::RCON[N-1-s]);
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= '0;
        end
        else if (advance)
        begin
            stage_vld_reg <= stage_vld_next;
        end
    end

    // data regs load on every advance; bubbles carry don't-care data
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < N; i++)
            begin
                stage_key_reg[i] <= stage_key_next[i];
            end
        end
    end

    assign key_out.valid         = stage_vld_reg[N-1];
    assign key_out.cipher_key_hi = stage_key_reg[N-1][W-1:aesiks_pkg::HALF_W];
    assign key_out.cipher_key_lo = stage_key_reg[N-1][aesiks_pkg::HALF_W-1:0];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // a held output word must block intake
    `AESIKS_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
        key_out.valid && !key_out.ready, !key_in.ready,
        "input accepted while output stalled")

    // words in flight: count changes only by accepts in minus words out
    `AESIKS_ASSERT_NEXT(a_word_conservation, clk, rst_n,
        rst_n,
        $countones(stage_vld_reg) ==
            $past($countones(stage_vld_reg)) + $past(in_fire) - $past(out_fire),
        "word lost or duplicated in pipe")

    // a frozen pipe keeps every valid bit
    `AESIKS_ASSERT_NEXT(a_freeze_holds, clk, rst_n,
        !advance, $stable(stage_vld_reg),
        "valid bits moved while pipe frozen")

endmodule

### dv/aes128_inverse_key_schedule_core_tb.sv
// Self-checking testbench for the AES-128 inverse key schedule core.
// Depends on aesiks_pkg, aesiks_key_in_if, aesiks_key_out_if and the core itself.
module aes128_inverse_key_schedule_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 150;    // long output back-pressure stretch
    localparam int DRAIN_CYCLES = 30;     // pipe is 10 deep; margin on top
    localparam int CYCLE_LIMIT  = 100000;
    localparam int MAX_REPORTS  = 10;

    // One 128-bit key split the way the channels carry it.
    typedef struct packed {
        logic [aesiks_pkg::HALF_W-1:0] hi;
        logic [aesiks_pkg::HALF_W-1:0] lo;
    } key_pair_t;

    // Predicts the cipher key for each accepted round-10 key and checks
    // outgoing words against the oldest prediction.
    class cipher_key_scoreboard;
        key_pair_t pending_keys[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Run the expansion backwards from W[40..43] down to W[0..3].
        function key_pair_t recover_cipher_key(input key_pair_t round_key);
            logic [31:0] win [4];
            logic [31:0] feed;
            logic [31:0] rotated;
            logic [31:0] next_word;
            key_pair_t   result;
            win[0] = round_key.hi[63:32];
            win[1] = round_key.hi[31:0];
            win[2] = round_key.lo[63:32];
            win[3] = round_key.lo[31:0];
            for (int t = 39; t >= 0; t--)
            begin
                feed = win[2];
                // every fourth word takes RotWord, SubWord and the round constant
                if (t % 4 == 0)
                begin
                    rotated = {feed[23:0], feed[31:24]};
                    feed = {aesiks_pkg::SBOX[rotated[31:24]], aesiks_pkg::SBOX[rotated[23:16]],
                            aesiks_pkg::SBOX[rotated[15:8]], aesiks_pkg::SBOX[rotated[7:0]]}
                           ^ {aesiks_pkg::RCON[(t / 4) % aesiks_pkg::NUM_ROUNDS], 24'h000000};
                end
                next_word = win[3] ^ feed;
                win[3] = win[2];
                win[2] = win[1];
                win[1] = win[0];
                win[0] = next_word;
            end
            result.hi = {win[0], win[1]};
            result.lo = {win[2], win[3]};
            return result;
        endfunction

        function void note_round_key(input key_pair_t round_key);
            pending_keys.push_back(recover_cipher_key(round_key));
        endfunction

        function void check_cipher_key(input key_pair_t got);
            key_pair_t want;
            if (pending_keys.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected cipher key word hi=%h lo=%h",
                             $realtime, got.hi, got.lo);
                return;
            end
            want = pending_keys.pop_front();
            if (got.hi !== want.hi || got.lo !== want.lo)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] cipher key mismatch: hi exp %h got %h, lo exp %h got %h",
                             $realtime, want.hi, got.hi, want.lo, got.lo);
            end
        endfunction

        function int outstanding();
            return pending_keys.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;

    // Idle percentages per side; changed by the stimulus between phases.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    // Output hold-off: the stimulus fires the event, the hold process
    // owns the count and the flag.
    event start_hold;
    logic hold_active = 1'b0;

    cipher_key_scoreboard key_board = new();

    aesiks_key_in_if  key_in();
    aesiks_key_out_if key_out();

    aes128_inverse_key_schedule_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_in (key_in),
        .key_out(key_out)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop in case the pipe hangs or words go missing.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("aes128_inverse_key_schedule_core test failed");
            $finish;
        end
    end

    // Long back-pressure stretch. Flag moves by NBA so the receiver
    // process below sees it from the next edge on, with no race.
    initial
    begin
        @(start_hold);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Receiver: random ready, forced low during the hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            key_out.ready <= 1'b0;
        else if (hold_active)
            key_out.ready <= 1'b0;
        else
            key_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both channels are sampled here at the edge, before any NBA of this
    // step lands. Input is noted first so a prediction is always queued
    // before the matching word can be checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (key_in.valid && key_in.ready)
                key_board.note_round_key('{key_in.last_key_hi, key_in.last_key_lo});
            if (key_out.valid && key_out.ready)
                key_board.check_cipher_key('{key_out.cipher_key_hi, key_out.cipher_key_lo});
        end
    end

    // Offer one round key and return right after the edge that takes it.
    // Valid is written once per step: either dropped for a gap or held high.
    task automatic send_round_key(input key_pair_t round_key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            key_in.valid <= 1'b0;
            @(posedge clk);
        end
        key_in.valid       <= 1'b1;
        key_in.last_key_hi <= round_key.hi;
        key_in.last_key_lo <= round_key.lo;
        do
            @(posedge clk);
        while (!key_in.ready);
    endtask

    // Mostly dense random keys; some with whole words stuck at 0 or all-ones
    // to exercise S-box inputs 00/ff and trivial XOR chains.
    function automatic key_pair_t random_round_key();
        logic [31:0] words [4];
        key_pair_t   rk;
        for (int i = 0; i < 4; i++)
        begin
            case ($urandom_range(7))
                0:       words[i] = 32'h0000_0000;
                1:       words[i] = 32'hffff_ffff;
                default: words[i] = $urandom;
            endcase
        end
        if ($urandom_range(3) != 0)
            for (int i = 0; i < 4; i++)
                words[i] = $urandom;
        rk.hi = {words[0], words[1]};
        rk.lo = {words[2], words[3]};
        return rk;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_round_key(random_round_key());
    endtask

    initial
    begin
        key_pair_t directed [$];

        rst_n               = 1'b0;
        key_in.valid        = 1'b0;
        key_in.last_key_hi  = '0;
        key_in.last_key_lo  = '0;
        key_out.ready       = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: extremes, half patterns, checkerboards, single
        // bits at both ends and in the middle, and the standard FIPS-197
        // round-10 key (expected cipher key 2b7e1516...09cf4f3c).
        directed.push_back('{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000});
        directed.push_back('{64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
        directed.push_back('{64'hffff_ffff_ffff_ffff, 64'h0000_0000_0000_0000});
        directed.push_back('{64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff});
        directed.push_back('{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555});
        directed.push_back('{64'haaaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa});
        directed.push_back('{64'h8000_0000_0000_0000, 64'h0000_0000_0000_0000});
        directed.push_back('{64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001});
        directed.push_back('{64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000});
        directed.push_back('{64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000});
        directed.push_back('{64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00});
        directed.push_back('{64'hd014_f9a8_c9ee_2589, 64'he13f_0cc8_b663_0ca6});
        directed.push_back('{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210});
        directed.push_back('{64'h6363_6363_6363_6363, 64'h6363_6363_6363_6363});

        // Directed words back to back, then the first six once more with light idling.
        foreach (directed[i])
            send_round_key(directed[i]);
        send_idle_pct = 30;
        recv_idle_pct = 30;
        for (int i = 0; i < 6; i++)
            send_round_key(directed[i]);

        // Phase 1: sender mostly busy, receiver idles half the time.
        // The hold-off lands early here, so the pipe fills and key_in stalls.
        send_idle_pct = 19;
        recv_idle_pct = 52;
        -> start_hold;
        run_random(530);

        // Phase 2: roles swapped.
        send_idle_pct = 52;
        recv_idle_pct = 19;
        run_random(530);

        // Phase 3: full rate both ways.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(540);

        key_in.valid <= 1'b0;

        while (key_board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (key_board.mismatches == 0 && key_board.outstanding() == 0)
            $display("aes128_inverse_key_schedule_core test passed");
        else
            $display("aes128_inverse_key_schedule_core test failed");
        $finish;
    end

endmodule
